/* design/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* design/ksivc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package ksivc_pkg;

	localparam int KSIVC_SLOTS = 32;
	localparam int SLOT_W      = 6;
	localparam int IV_W        = 64;

	localparam logic [1:0] OP_RETRIEVE  = 2'd0;
	localparam logic [1:0] OP_DEPOSIT   = 2'd1;
	localparam logic [1:0] OP_CLEAR_ALL = 2'd2;

	localparam logic [1:0] DIR_ENC  = 2'd0;
	localparam logic [1:0] DIR_DEC  = 2'd1;
	localparam logic [1:0] DIR_BOTH = 2'd2;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_BAD_SLOT  = 2'd1;
	localparam logic [1:0] ST_EXHAUSTED = 2'd2;

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	typedef struct packed {
		logic [1:0]        operation;
		logic [SLOT_W-1:0] slot;
		logic [1:0]        direction;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] enc_iv_high;
		logic [31:0] enc_iv_low;
		logic [31:0] dec_iv_high;
		logic [31:0] dec_iv_low;
	} rsp_t;

endpackage
`default_nettype wire

/* design/key_slot_iv_counter_store.sv */
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  Signals                        Transfer
// req       in         req_valid, req_ready, req      req_valid & req_ready
// rsp       out        rsp_valid, rsp_ready, rsp      rsp_valid & rsp_ready
// cfg       in         cfg_we, cfg_wdata              cfg_we
//
// The transfer cycle issues the slot read; S_EXEC then modifies, writes back
// both IV memories for a retrieve or deposit on a valid slot and loads the
// result register. A result still held in the result register stalls S_EXEC.
// Reset clears one valid bit per slot; an entry without it reads as zero.
// Clear-all drops every valid bit at once.
`include "assert_macros.svh"
module key_slot_iv_counter_store #(
	parameter int SLOTS = ksivc_pkg::KSIVC_SLOTS
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            req_valid,
	output logic                 req_ready,
	input  wire ksivc_pkg::req_t req,
	output logic                 rsp_valid,
	input  wire logic            rsp_ready,
	output ksivc_pkg::rsp_t      rsp,
	input  wire logic            cfg_we,
	input  wire logic            cfg_wdata
);
	import ksivc_pkg::*;

	localparam int AW = $clog2(SLOTS);
	localparam logic [SLOT_W:0] SLOTS_W = (SLOT_W+1)'(SLOTS);

	state_t            state_q, state_d;
	req_t              req_s1;
	logic              mode_q;
	logic [SLOTS-1:0]  valid_q;
	rsp_t              rsp_q, rsp_d;
	logic              rsp_valid_q;

	logic              req_xfer, rsp_free, exec_go;
	logic              slot_ok, entry_valid;
	logic [AW-1:0]     idx;
	logic [IV_W-1:0]   enc_rdata, dec_rdata;
	logic [IV_W-1:0]   enc_cur, dec_cur, enc_new, dec_new;
	logic              use_e, use_d, exh_e, exh_d, enc_ok, all_ok;
	logic              ram_we;

	assign req_xfer  = req_valid && req_ready;
	assign rsp_free  = !rsp_valid_q || rsp_ready;
	assign exec_go   = (state_q == S_EXEC) && rsp_free;
	assign idx       = req_s1.slot[AW-1:0];
	assign slot_ok   = {1'b0, req_s1.slot} < SLOTS_W;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	ksivc_ram #(.WIDTH(IV_W), .DEPTH(SLOTS)) u_enc_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (idx),
		.wdata (enc_new),
		.re    (req_xfer),
		.raddr (req.slot[AW-1:0]),
		.rdata (enc_rdata)
	);

	ksivc_ram #(.WIDTH(IV_W), .DEPTH(SLOTS)) u_dec_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (idx),
		.wdata (dec_new),
		.re    (req_xfer),
		.raddr (req.slot[AW-1:0]),
		.rdata (dec_rdata)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				if (rsp_free) begin
					state_d = S_IDLE;
				end
			end
		endcase
	end

	always_comb begin
		req_ready   = (state_q == S_IDLE);
		entry_valid = slot_ok && valid_q[idx];
		enc_cur     = entry_valid ? enc_rdata : '0;
		dec_cur     = entry_valid ? dec_rdata : '0;
		use_e       = (req_s1.operation == OP_RETRIEVE) &&
			((req_s1.direction == DIR_ENC) || (req_s1.direction == DIR_BOTH));
		use_d       = (req_s1.operation == OP_RETRIEVE) &&
			((req_s1.direction == DIR_DEC) || (req_s1.direction == DIR_BOTH));
		exh_e       = mode_q ? (enc_cur[63:32] == '1) : (enc_cur == '1);
		exh_d       = mode_q ? (dec_cur[63:32] == '1) : (dec_cur == '1);
		enc_ok      = !use_e || !exh_e;
		all_ok      = enc_ok && (!use_d || !exh_d);
		enc_new     = enc_cur;
		dec_new     = dec_cur;
		if (req_s1.operation == OP_DEPOSIT) begin
			enc_new = '0;
			dec_new = '0;
		end else begin
			if (use_e && !exh_e && mode_q) begin
				enc_new = {enc_cur[63:32] + 32'd1, enc_cur[31:0]};
			end
			if (use_d && enc_ok && !exh_d && mode_q) begin
				dec_new = {dec_cur[63:32] + 32'd1, dec_cur[31:0]};
			end
		end
		ram_we = exec_go && slot_ok &&
			((req_s1.operation == OP_RETRIEVE) || (req_s1.operation == OP_DEPOSIT));
		rsp_d  = '0;
		priority if (req_s1.operation == OP_CLEAR_ALL) begin
			rsp_d.status = ST_OK;
		end else if (!slot_ok) begin
			rsp_d.status = ST_BAD_SLOT;
		end else begin
			rsp_d.status      = all_ok ? ST_OK : ST_EXHAUSTED;
			rsp_d.enc_iv_high = enc_new[63:32];
			rsp_d.enc_iv_low  = enc_new[31:0];
			rsp_d.dec_iv_high = dec_new[63:32];
			rsp_d.dec_iv_low  = dec_new[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			mode_q      <= 1'b0;
			valid_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				mode_q <= cfg_wdata;
			end
			if (exec_go && (req_s1.operation == OP_CLEAR_ALL)) begin
				valid_q <= '0;
			end else if (ram_we) begin
				valid_q[idx] <= 1'b1;
			end
			if (exec_go) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_xfer) begin
			req_s1 <= req;
		end
		if (exec_go) begin
			rsp_q <= rsp_d;
		end
	end

	`ASSERT_CLK(a_we_in_exec, ram_we |-> (state_q == S_EXEC), "memory write outside exec")
	`ASSERT_CLK(a_xfer_to_exec, req_xfer |=> (state_q == S_EXEC), "transfer did not start exec")
	`ASSERT_CLK(a_bad_no_write, ((state_q == S_EXEC) && !slot_ok) |-> !ram_we,
		"write for invalid slot")
	`ASSERT_CLK(a_clear_all, (exec_go && (req_s1.operation == OP_CLEAR_ALL)) |=> (valid_q == '0),
		"clear-all left valid slots")
	`ASSERT_ALWAYS(a_reset_idle, !arst_n |=> ((state_q == S_IDLE) && !rsp_valid_q),
		"not idle in reset")

endmodule
`default_nettype wire

/* design/ksivc_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
module ksivc_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

/* verif/key_slot_iv_counter_store_test.sv */
`timescale 1ns / 1ps
module key_slot_iv_counter_store_test;
	import ksivc_pkg::*;

	localparam logic [1:0] OP_PEEK     = 2'd3;
	localparam logic [1:0] DIR_NONE    = 2'd3;
	localparam int         STALL_LIMIT = 2000;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	req_t req;
	logic rsp_valid;
	logic rsp_ready;
	rsp_t rsp;
	logic cfg_we;
	logic cfg_wdata;

	logic [IV_W-1:0] enc_iv_shadow [KSIVC_SLOTS];
	logic [IV_W-1:0] dec_iv_shadow [KSIVC_SLOTS];
	logic            mode_32;
	rsp_t            pending_iv_rsp [$];

	int error_count = 0;
	int results_checked = 0;
	int idle_cycles = 0;
	int req_idle_pct = 8;
	int rsp_stall_pct = 8;
	int n_retrieve = 0;
	int n_deposit = 0;
	int n_clear = 0;
	int n_bad_slot = 0;
	int n_mode_writes = 0;

	key_slot_iv_counter_store u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	function automatic logic advance_iv(input logic decrypt, input int s);
		logic [IV_W-1:0] ctr;
		ctr = decrypt ? dec_iv_shadow[s] : enc_iv_shadow[s];
		if (!mode_32)
			return ctr != '1;
		if (ctr[63:32] == '1)
			return 1'b0;
		ctr[63:32] = ctr[63:32] + 32'd1;
		if (decrypt)
			dec_iv_shadow[s] = ctr;
		else
			enc_iv_shadow[s] = ctr;
		return 1'b1;
	endfunction

	function automatic rsp_t rotate_ivs(input req_t item);
		rsp_t r;
		logic ok;
		int s;
		r = '0;
		r.status = ST_OK;
		s = int'(item.slot);
		if (item.operation == OP_CLEAR_ALL) begin
			for (int i = 0; i < KSIVC_SLOTS; i++) begin
				enc_iv_shadow[i] = '0;
				dec_iv_shadow[i] = '0;
			end
		end else if (s >= KSIVC_SLOTS) begin
			r.status = ST_BAD_SLOT;
		end else begin
			if (item.operation == OP_DEPOSIT) begin
				enc_iv_shadow[s] = '0;
				dec_iv_shadow[s] = '0;
			end else if (item.operation == OP_RETRIEVE) begin
				ok = 1'b1;
				if (item.direction == DIR_ENC || item.direction == DIR_BOTH)
					ok = advance_iv(1'b0, s);
				if (ok && (item.direction == DIR_DEC || item.direction == DIR_BOTH))
					ok = advance_iv(1'b1, s);
				if (!ok)
					r.status = ST_EXHAUSTED;
			end
			r.enc_iv_high = enc_iv_shadow[s][63:32];
			r.enc_iv_low  = enc_iv_shadow[s][31:0];
			r.dec_iv_high = dec_iv_shadow[s][63:32];
			r.dec_iv_low  = dec_iv_shadow[s][31:0];
		end
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		error_count++;
		if (error_count <= 50)
			$display("[%0t] mismatch: %s", $realtime, msg);
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %h expected %h", name, got, want));
	endtask

	// Hold valid across back-to-back transfers; drop it only while idle cycles are inserted.
	task automatic send_iv_request(input logic [1:0] op, input logic [5:0] slot,
			input logic [1:0] dir);
		req_t item;
		item.operation = op;
		item.slot      = slot;
		item.direction = dir;
		@(negedge clk);
		while ($urandom_range(99) < req_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req       <= item;
		do @(posedge clk); while (req_ready !== 1'b1);
		pending_iv_rsp.push_back(rotate_ivs(item));
		if (op == OP_CLEAR_ALL)
			n_clear++;
		else if (slot >= KSIVC_SLOTS)
			n_bad_slot++;
		else if (op == OP_DEPOSIT)
			n_deposit++;
		else
			n_retrieve++;
	endtask

	task automatic drain_ivs();
		@(negedge clk);
		req_valid <= 1'b0;
		while (pending_iv_rsp.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_counter_mode(input logic m);
		drain_ivs();
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= m;
		@(negedge clk);
		cfg_we    <= 1'b0;
		mode_32 = m;
		n_mode_writes++;
	endtask

	task automatic test_reset_state();
		send_iv_request(OP_RETRIEVE, 6'd0, DIR_ENC);
		send_iv_request(OP_RETRIEVE, 6'd31, DIR_DEC);
		send_iv_request(OP_RETRIEVE, 6'd17, DIR_BOTH);
		send_iv_request(OP_RETRIEVE, 6'd5, DIR_NONE);
		send_iv_request(OP_PEEK, 6'd31, DIR_BOTH);
	endtask

	task automatic test_bad_slots();
		send_iv_request(OP_RETRIEVE, 6'd32, DIR_ENC);
		send_iv_request(OP_DEPOSIT, 6'd63, DIR_NONE);
		send_iv_request(OP_PEEK, 6'd45, DIR_DEC);
		send_iv_request(OP_RETRIEVE, 6'd63, DIR_BOTH);
	endtask

	task automatic test_counter_increment();
		set_counter_mode(1'b1);
		send_iv_request(OP_RETRIEVE, 6'd0, DIR_ENC);
		send_iv_request(OP_RETRIEVE, 6'd0, DIR_DEC);
		send_iv_request(OP_RETRIEVE, 6'd0, DIR_BOTH);
		send_iv_request(OP_RETRIEVE, 6'd0, DIR_NONE);
		send_iv_request(OP_RETRIEVE, 6'd31, DIR_BOTH);
		send_iv_request(OP_RETRIEVE, 6'd31, DIR_BOTH);
		send_iv_request(OP_PEEK, 6'd0, DIR_ENC);
	endtask

	task automatic test_deposit();
		send_iv_request(OP_DEPOSIT, 6'd0, DIR_BOTH);
		send_iv_request(OP_RETRIEVE, 6'd0, DIR_BOTH);
		send_iv_request(OP_DEPOSIT, 6'd31, DIR_ENC);
	endtask

	task automatic test_clear_all();
		send_iv_request(OP_RETRIEVE, 6'd1, DIR_BOTH);
		send_iv_request(OP_CLEAR_ALL, 6'd63, DIR_NONE);
		send_iv_request(OP_RETRIEVE, 6'd31, DIR_ENC);
		send_iv_request(OP_RETRIEVE, 6'd1, DIR_NONE);
	endtask

	task automatic test_mode_zero();
		set_counter_mode(1'b0);
		send_iv_request(OP_RETRIEVE, 6'd1, DIR_BOTH);
		send_iv_request(OP_RETRIEVE, 6'd31, DIR_BOTH);
	endtask

	task automatic test_random_traffic(input logic m, input int count, input int pct);
		int roll;
		logic [1:0] op;
		logic [5:0] slot;
		set_counter_mode(m);
		req_idle_pct  = pct;
		rsp_stall_pct = pct;
		for (int i = 0; i < count; i++) begin
			roll = $urandom_range(99);
			if (roll < 2)
				op = OP_CLEAR_ALL;
			else if (roll < 10)
				op = OP_DEPOSIT;
			else if (roll < 14)
				op = OP_PEEK;
			else
				op = OP_RETRIEVE;
			roll = $urandom_range(99);
			if (roll < 6)
				slot = 6'($urandom_range(63, KSIVC_SLOTS));
			else if (roll < 50)
				slot = 6'($urandom_range(3));
			else
				slot = 6'($urandom_range(KSIVC_SLOTS - 1));
			send_iv_request(op, slot, 2'($urandom_range(3)));
		end
		req_idle_pct  = 8;
		rsp_stall_pct = 8;
	endtask

	always @(negedge clk)
		rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);

	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (pending_iv_rsp.size() == 0) begin
				report_mismatch($sformatf("unexpected transfer, status %0d", rsp.status));
			end else begin
				want = pending_iv_rsp.pop_front();
				results_checked++;
				check_field("status", 32'(rsp.status), 32'(want.status));
				check_field("enc_iv_high", rsp.enc_iv_high, want.enc_iv_high);
				check_field("enc_iv_low", rsp.enc_iv_low, want.enc_iv_low);
				check_field("dec_iv_high", rsp.dec_iv_high, want.dec_iv_high);
				check_field("dec_iv_low", rsp.dec_iv_low, want.dec_iv_low);
			end
		end
	end

	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		arst_n    = 1'b0;
		req_valid = 1'b0;
		req       = '0;
		cfg_we    = 1'b0;
		cfg_wdata = 1'b0;
		mode_32   = 1'b0;
		for (int i = 0; i < KSIVC_SLOTS; i++) begin
			enc_iv_shadow[i] = '0;
			dec_iv_shadow[i] = '0;
		end
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_state();
		test_bad_slots();
		test_counter_increment();
		test_deposit();
		test_clear_all();
		test_mode_zero();
		test_random_traffic(1'b1, 600, 8);
		test_random_traffic(1'b0, 300, 8);
		test_random_traffic(1'b1, 500, 0);
		test_random_traffic(1'b1, 300, 8);
		drain_ivs();
		repeat (10) @(posedge clk);

		$display("Ran %0d retrieves, %0d deposits, %0d clear-alls and %0d bad-slot requests",
			n_retrieve, n_deposit, n_clear, n_bad_slot);
		$display("across %0d counter mode writes; %0d results compared, %0d mismatches",
			n_mode_writes, results_checked, error_count);
		if (error_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

/* files.f */
+incdir+design
design/ksivc_pkg.sv
design/ksivc_ram.sv
design/key_slot_iv_counter_store.sv
verif/key_slot_iv_counter_store_test.sv
